// ===== hw/rtl/rgb_led_effect_generator_defines.svh =====
// Assertion macros shared by the RGB LED effect generator checks.
// Stand-alone header; no other file is required.
`ifndef RGB_LED_EFFECT_GENERATOR_DEFINES_SVH
`define RGB_LED_EFFECT_GENERATOR_DEFINES_SVH

// Overlapping implication, sampled on the rising clock edge, off during reset.
`define RLEG_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rleg check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RLEG_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rleg check failed");

`endif

// ===== hw/rtl/rleg_pkg.sv =====
// Types and constants of the RGB LED effect generator.
// Stand-alone package; used by rgb_led_effect_generator.
package rleg_pkg;

    typedef enum logic [1:0] {
        MODE_STEADY  = 2'd0,
        MODE_BLINK   = 2'd1,
        MODE_FADE    = 2'd2,
        MODE_RAINBOW = 2'd3
    } mode_t;

    localparam int unsigned CFG_INDEX_WIDTH   = 3;
    localparam int unsigned FRAME_DELAY_WIDTH = 24;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_RED    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_GREEN  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_BLUE   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EFFECT_MODE = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_DELAY = 3'd4;

    localparam logic [FRAME_DELAY_WIDTH-1:0] FRAME_DELAY_RESET = 24'd500000;

    // Fade shifts the frame delay down by this many bits.
    localparam int unsigned FADE_DELAY_SHIFT = 8;

    // Hue is held as sector (0..5) and offset in sector (0..59).
    localparam logic [5:0] HUE_SECTOR_SPAN  = 6'd60;
    localparam logic [2:0] HUE_SECTOR_LAST  = 3'd5;

    localparam logic [7:0] CHANNEL_FULL = 8'd255;

endpackage

// ===== hw/rtl/rgb_led_effect_generator.sv =====
// RGB LED effect generator (steady, blink, fade, rainbow), one transaction per time tick.
// A tick that makes a frame shows it on m_* from the cycle after acceptance.
// Throughput: one tick per cycle; s_ready drops only while a frame waits on m_ready.
// Reset (aresetn, synchronous, active low): pattern state and countdown clear, so
// the first tick emits; registers take their reset values. Depends on rleg_pkg.
module rgb_led_effect_generator #(
    parameter int unsigned DELAY_WIDTH   = 24,
    parameter int unsigned HUE_INCREMENT = 2
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rleg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [rleg_pkg::FRAME_DELAY_WIDTH-1:0] cfg_data,
    // tick channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_restart,
    // frame channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [7:0]                           m_red,
    output logic [7:0]                           m_green,
    output logic [7:0]                           m_blue
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted, since cfg_ready is tied high.
    // ------------------------------------------------------------------
    logic [7:0]                              base_red_reg;
    logic [7:0]                              base_green_reg;
    logic [7:0]                              base_blue_reg;
    rleg_pkg::mode_t                         effect_mode_reg;
    logic [rleg_pkg::FRAME_DELAY_WIDTH-1:0]  frame_delay_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_red_reg    <= '0;
            base_green_reg  <= '0;
            base_blue_reg   <= '0;
            effect_mode_reg <= rleg_pkg::MODE_STEADY;
            frame_delay_reg <= rleg_pkg::FRAME_DELAY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rleg_pkg::REG_BASE_RED:    base_red_reg    <= cfg_data[7:0];
                rleg_pkg::REG_BASE_GREEN:  base_green_reg  <= cfg_data[7:0];
                rleg_pkg::REG_BASE_BLUE:   base_blue_reg   <= cfg_data[7:0];
                rleg_pkg::REG_EFFECT_MODE: effect_mode_reg <= rleg_pkg::mode_t'(cfg_data[1:0]);
                rleg_pkg::REG_FRAME_DELAY: frame_delay_reg <= cfg_data;
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pattern state. The hue is kept as sector and offset so that the
    // color ramp needs no division by 60.
    // ------------------------------------------------------------------
    logic [DELAY_WIDTH-1:0] countdown_reg,   countdown_next;
    logic                   blink_phase_reg, blink_phase_next;
    logic [7:0]             fade_level_reg,  fade_level_next;
    logic                   fade_falling_reg, fade_falling_next;
    logic [2:0]             hue_sector_reg,  hue_sector_next;
    logic [5:0]             hue_offset_reg,  hue_offset_next;
    logic                   steady_sent_reg, steady_sent_next;

    // Output register: holds one finished frame until m_ready takes it.
    logic                   m_valid_reg;
    logic [7:0]             m_red_reg, m_green_reg, m_blue_reg;

    logic                   tick_accept;
    logic                   emit;
    logic [7:0]             red_next, green_next, blue_next;

    // Accept a tick whenever the output register is free or being drained.
    assign s_ready     = !m_valid_reg || m_ready;
    assign tick_accept = s_valid && s_ready;

    // x * level / 255 for a 16-bit product, exact over the full range.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        begin
            t = {1'b0, p} + 17'(p[15:8]) + 17'd1;
            div255 = t[15:8];
        end
    endfunction

    // Restart clears the pattern before the tick is handled.
    logic [DELAY_WIDTH-1:0] cd_eff;
    logic                   blink_eff, fall_eff, steady_eff;
    logic [7:0]             level_eff;
    logic [2:0]             sector_eff;
    logic [5:0]             offset_eff;

    assign cd_eff     = s_restart ? '0    : countdown_reg;
    assign blink_eff  = s_restart ? 1'b0  : blink_phase_reg;
    assign fall_eff   = s_restart ? 1'b0  : fade_falling_reg;
    assign steady_eff = s_restart ? 1'b0  : steady_sent_reg;
    assign level_eff  = s_restart ? 8'd0  : fade_level_reg;
    assign sector_eff = s_restart ? 3'd0  : hue_sector_reg;
    assign offset_eff = s_restart ? 6'd0  : hue_offset_reg;

    // Frame period: fade uses delay/256, zero counts as one, saturate to
    // the countdown range.
    logic [rleg_pkg::FRAME_DELAY_WIDTH-1:0] period_raw;
    logic [DELAY_WIDTH-1:0]                 period_sat;

    always_comb begin
        if (effect_mode_reg == rleg_pkg::MODE_FADE) begin
            period_raw = frame_delay_reg >> rleg_pkg::FADE_DELAY_SHIFT;
        end else begin
            period_raw = frame_delay_reg;
        end
        if (period_raw == '0) begin
            period_raw = rleg_pkg::FRAME_DELAY_WIDTH'(1);
        end
        if ((period_raw >> DELAY_WIDTH) != '0) begin
            period_sat = '1;
        end else begin
            period_sat = DELAY_WIDTH'(period_raw);
        end
    end

    // Rainbow ramp: floor(d*255/60) = floor(d*17/4); falling sectors use 60-d.
    logic [5:0] ramp_d;
    logic [9:0] ramp_prod;
    logic [7:0] ramp_x;
    logic [6:0] offset_sum;

    assign ramp_d     = sector_eff[0] ? (rleg_pkg::HUE_SECTOR_SPAN - offset_eff) : offset_eff;
    assign ramp_prod  = 10'(ramp_d) * 10'd17;
    assign ramp_x     = ramp_prod[9:2];
    assign offset_sum = {1'b0, offset_eff} + 7'(HUE_INCREMENT);

    // Fade products, one 8x8 multiply per channel.
    logic [15:0] fade_r, fade_g, fade_b;

    assign fade_r = 16'(base_red_reg)   * 16'(level_eff);
    assign fade_g = 16'(base_green_reg) * 16'(level_eff);
    assign fade_b = 16'(base_blue_reg)  * 16'(level_eff);

    always_comb begin
        countdown_next    = cd_eff;
        blink_phase_next  = blink_eff;
        fade_level_next   = level_eff;
        fade_falling_next = fall_eff;
        hue_sector_next   = sector_eff;
        hue_offset_next   = offset_eff;
        steady_sent_next  = steady_eff;
        emit              = 1'b0;
        red_next          = base_red_reg;
        green_next        = base_green_reg;
        blue_next         = base_blue_reg;

        if (effect_mode_reg == rleg_pkg::MODE_STEADY) begin
            // Steady ignores the countdown and emits once after reset or a restart.
            if (!steady_eff) begin
                steady_sent_next = 1'b1;
                emit             = 1'b1;
            end
        end else if (cd_eff != '0) begin
            countdown_next = cd_eff - 1'b1;
        end else begin
            countdown_next = period_sat - 1'b1;
            emit           = 1'b1;
            case (effect_mode_reg)
                rleg_pkg::MODE_BLINK: begin
                    if (blink_eff) begin
                        red_next   = '0;
                        green_next = '0;
                        blue_next  = '0;
                    end
                    blink_phase_next = !blink_eff;
                end
                rleg_pkg::MODE_FADE: begin
                    red_next   = div255(fade_r);
                    green_next = div255(fade_g);
                    blue_next  = div255(fade_b);
                    // Hold the end levels for one extra frame at each turnaround.
                    if (!fall_eff) begin
                        if (level_eff == rleg_pkg::CHANNEL_FULL) begin
                            fade_falling_next = 1'b1;
                        end else begin
                            fade_level_next = level_eff + 8'd1;
                        end
                    end else begin
                        if (level_eff == 8'd0) begin
                            fade_falling_next = 1'b0;
                        end else begin
                            fade_level_next = level_eff - 8'd1;
                        end
                    end
                end
                default: begin
                    case (sector_eff)
                        3'd0: begin
                            red_next = rleg_pkg::CHANNEL_FULL; green_next = ramp_x; blue_next = '0;
                        end
                        3'd1: begin
                            red_next = ramp_x; green_next = rleg_pkg::CHANNEL_FULL; blue_next = '0;
                        end
                        3'd2: begin
                            red_next = '0; green_next = rleg_pkg::CHANNEL_FULL; blue_next = ramp_x;
                        end
                        3'd3: begin
                            red_next = '0; green_next = ramp_x; blue_next = rleg_pkg::CHANNEL_FULL;
                        end
                        3'd4: begin
                            red_next = ramp_x; green_next = '0; blue_next = rleg_pkg::CHANNEL_FULL;
                        end
                        default: begin
                            red_next = rleg_pkg::CHANNEL_FULL; green_next = '0; blue_next = ramp_x;
                        end
                    endcase
                    // Advance the hue; wrap to zero when the next hue reaches 360.
                    if (offset_sum >= 7'(rleg_pkg::HUE_SECTOR_SPAN)) begin
                        if (sector_eff == rleg_pkg::HUE_SECTOR_LAST) begin
                            hue_sector_next = 3'd0;
                            hue_offset_next = 6'd0;
                        end else begin
                            hue_sector_next = sector_eff + 3'd1;
                            hue_offset_next = 6'(offset_sum - 7'(rleg_pkg::HUE_SECTOR_SPAN));
                        end
                    end else begin
                        hue_offset_next = offset_sum[5:0];
                    end
                end
            endcase
        end
    end

    // Advance pattern state on every accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            countdown_reg    <= '0;
            blink_phase_reg  <= 1'b0;
            fade_level_reg   <= '0;
            fade_falling_reg <= 1'b0;
            hue_sector_reg   <= '0;
            hue_offset_reg   <= '0;
            steady_sent_reg  <= 1'b0;
        end else if (tick_accept) begin
            countdown_reg    <= countdown_next;
            blink_phase_reg  <= blink_phase_next;
            fade_level_reg   <= fade_level_next;
            fade_falling_reg <= fade_falling_next;
            hue_sector_reg   <= hue_sector_next;
            hue_offset_reg   <= hue_offset_next;
            steady_sent_reg  <= steady_sent_next;
        end
    end

    // Output register: load a frame on an emitting tick, drop valid once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tick_accept) begin
            m_valid_reg <= emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_accept && emit) begin
            m_red_reg   <= red_next;
            m_green_reg <= green_next;
            m_blue_reg  <= blue_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = m_red_reg;
    assign m_green = m_green_reg;
    assign m_blue  = m_blue_reg;

endmodule

// ===== hw/rtl/rleg_port_check.sv =====
// Port-level checks of the RGB LED effect generator, attached by bind.
// Depends on rgb_led_effect_generator_defines.svh.
`include "rgb_led_effect_generator_defines.svh"

module rleg_port_check (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_red,
    input logic [7:0] m_green,
    input logic [7:0] m_blue
);

    // A frame appears only after a tick transaction.
    `RLEG_ASSERT_NOW(a_frame_needs_tick, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready))
    // A stalled frame blocks new ticks.
    `RLEG_ASSERT_NOW(a_stall_blocks_tick, aclk, aresetn, m_valid && !m_ready, !s_ready)
    // A stalled frame stays valid.
    `RLEG_ASSERT_NEXT(a_frame_held, aclk, aresetn, m_valid && !m_ready, m_valid)
    // A stalled frame keeps its color.
    `RLEG_ASSERT_NEXT(a_color_held, aclk, aresetn, m_valid && !m_ready, $stable(m_red) && $stable(m_green) && $stable(m_blue))

endmodule

bind rgb_led_effect_generator rleg_port_check u_rleg_port_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_red   (m_red),
    .m_green (m_green),
    .m_blue  (m_blue)
);

// ===== tb/led_frame_checker.sv =====
// Frame checker for the RGB LED effect generator: tracks configuration and tick
// transactions, predicts every frame and compares the frame channel.
// Depends on rleg_pkg; instantiated beside the block by tb_top.
module led_frame_checker #(
    parameter int unsigned DELAY_WIDTH   = 24,
    parameter int unsigned HUE_INCREMENT = 2
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [rleg_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [rleg_pkg::FRAME_DELAY_WIDTH-1:0] cfg_data,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic                                   s_restart,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic [7:0]                             m_red,
    input  logic [7:0]                             m_green,
    input  logic [7:0]                             m_blue,
    output int unsigned                            mismatch_count,
    output int unsigned                            frames_pending,
    output int unsigned                            frames_checked
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_frame_t;

    localparam longint unsigned DELAY_MAX = (64'd1 << DELAY_WIDTH) - 1;
    localparam int unsigned     HUE_FULL  = 360;

    // register copies
    logic [7:0]                             base_red, base_green, base_blue;
    rleg_pkg::mode_t                        effect_mode;
    logic [rleg_pkg::FRAME_DELAY_WIDTH-1:0] frame_delay;

    // pattern state
    logic [DELAY_WIDTH-1:0] countdown;
    bit                     blink_dark;
    logic [7:0]             fade_level;
    bit                     fade_falling;
    int unsigned            hue_step;
    bit                     steady_done;

    rgb_frame_t expected_frames[$];

    task automatic clear_effect();
        countdown    = '0;
        blink_dark   = 1'b0;
        fade_level   = 8'd0;
        fade_falling = 1'b0;
        hue_step     = 0;
        steady_done  = 1'b0;
    endtask

    function automatic logic [7:0] fade_channel(logic [7:0] color, logic [7:0] level);
        int unsigned product;
        product = int'(color) * int'(level);
        return 8'(product / rleg_pkg::CHANNEL_FULL);
    endfunction

    // Advance the effect by one tick and return the frame it emits, if any.
    task automatic advance_effect(input logic restart, output bit emits,
                                  output rgb_frame_t frame);
        longint unsigned period;
        int unsigned     hue, sector, offset, ramp;
        emits = 1'b0;
        frame = '0;
        if (restart)
            clear_effect();
        if (effect_mode == rleg_pkg::MODE_STEADY) begin
            emits       = !steady_done;
            steady_done = 1'b1;
            frame       = {base_red, base_green, base_blue};
        end else if (countdown != 0) begin
            countdown = countdown - 1'b1;
        end else begin
            period = (effect_mode == rleg_pkg::MODE_FADE)
                   ? (frame_delay >> rleg_pkg::FADE_DELAY_SHIFT)
                   : frame_delay;
            if (period == 0)
                period = 1;
            if (period > DELAY_MAX)
                period = DELAY_MAX;
            countdown = DELAY_WIDTH'(period - 1);
            emits     = 1'b1;
            case (effect_mode)
                rleg_pkg::MODE_BLINK: begin
                    frame      = blink_dark ? '0 : {base_red, base_green, base_blue};
                    blink_dark = !blink_dark;
                end
                rleg_pkg::MODE_FADE: begin
                    frame = {fade_channel(base_red, fade_level),
                             fade_channel(base_green, fade_level),
                             fade_channel(base_blue, fade_level)};
                    if (!fade_falling) begin
                        if (fade_level == rleg_pkg::CHANNEL_FULL)
                            fade_falling = 1'b1;
                        else
                            fade_level++;
                    end else begin
                        if (fade_level == 8'd0)
                            fade_falling = 1'b0;
                        else
                            fade_level--;
                    end
                end
                default: begin
                    hue    = (hue_step * HUE_INCREMENT) % HUE_FULL;
                    sector = hue / rleg_pkg::HUE_SECTOR_SPAN;
                    offset = hue % rleg_pkg::HUE_SECTOR_SPAN;
                    // ramp climbs in even sectors and falls in odd ones
                    if (sector % 2 == 1)
                        ramp = ((rleg_pkg::HUE_SECTOR_SPAN - offset) * rleg_pkg::CHANNEL_FULL)
                             / rleg_pkg::HUE_SECTOR_SPAN;
                    else
                        ramp = (offset * rleg_pkg::CHANNEL_FULL) / rleg_pkg::HUE_SECTOR_SPAN;
                    case (sector)
                        0:       frame = {rleg_pkg::CHANNEL_FULL, 8'(ramp), 8'd0};
                        1:       frame = {8'(ramp), rleg_pkg::CHANNEL_FULL, 8'd0};
                        2:       frame = {8'd0, rleg_pkg::CHANNEL_FULL, 8'(ramp)};
                        3:       frame = {8'd0, 8'(ramp), rleg_pkg::CHANNEL_FULL};
                        4:       frame = {8'(ramp), 8'd0, rleg_pkg::CHANNEL_FULL};
                        default: frame = {rleg_pkg::CHANNEL_FULL, 8'd0, 8'(ramp)};
                    endcase
                    if ((hue_step + 1) * HUE_INCREMENT >= HUE_FULL)
                        hue_step = 0;
                    else
                        hue_step++;
                end
            endcase
        end
    endtask

    always @(posedge aclk) begin : frame_track
        bit         emits;
        rgb_frame_t predicted, want, got;
        if (!aresetn) begin
            base_red    = 8'd0;
            base_green  = 8'd0;
            base_blue   = 8'd0;
            effect_mode = rleg_pkg::MODE_STEADY;
            frame_delay = rleg_pkg::FRAME_DELAY_RESET;
            clear_effect();
            expected_frames.delete();
            mismatch_count = 0;
            frames_checked = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rleg_pkg::REG_BASE_RED:    base_red    = cfg_data[7:0];
                    rleg_pkg::REG_BASE_GREEN:  base_green  = cfg_data[7:0];
                    rleg_pkg::REG_BASE_BLUE:   base_blue   = cfg_data[7:0];
                    rleg_pkg::REG_EFFECT_MODE: effect_mode = rleg_pkg::mode_t'(cfg_data[1:0]);
                    rleg_pkg::REG_FRAME_DELAY: frame_delay = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                advance_effect(s_restart, emits, predicted);
                if (emits)
                    expected_frames.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                got = {m_red, m_green, m_blue};
                if (expected_frames.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected frame, expected none, got rgb %0d/%0d/%0d",
                             $time, got.red, got.green, got.blue);
                end else begin
                    want = expected_frames.pop_front();
                    frames_checked++;
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        mismatch_count++;
                        $display("%0t: frame %0d mismatch, expected rgb %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, frames_checked, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                    end
                end
            end
        end
        frames_pending = expected_frames.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the RGB LED effect generator testbench: clock, reset, tick stimulus,
// register writes, frame sink and verdict. Depends on rleg_pkg and led_frame_checker.
module tb_top;

    localparam int unsigned DELAY_WIDTH   = 24;
    localparam int unsigned HUE_INCREMENT = 2;
    localparam int unsigned LONG_HOLD     = 200;   // cycles the sink refuses frames once
    localparam int unsigned IDLE_LIMIT    = 2000;  // cycles without any transaction
    localparam int unsigned SETTLE_CYCLES = 4;     // quiet cycles before register writes
    localparam int unsigned TAIL_CYCLES   = 16;
    localparam int unsigned MIXED_PHASES  = 16;

    logic                                   aclk      = 1'b0;
    logic                                   aresetn   = 1'b0;
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [rleg_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index = '0;
    logic [rleg_pkg::FRAME_DELAY_WIDTH-1:0] cfg_data  = '0;
    logic                                   s_valid   = 1'b0;
    logic                                   s_ready;
    logic                                   s_restart = 1'b0;
    logic                                   m_valid;
    logic                                   m_ready   = 1'b0;
    logic [7:0]                             m_red, m_green, m_blue;

    int unsigned mismatch_count, frames_pending, frames_checked;
    int unsigned ticks_sent  = 0;
    int unsigned idle_cycles = 0;
    bit          sink_calm     = 1'b0;  // sink takes every frame at once while set
    bit          long_hold_req = 1'b0;  // raised by the stimulus, cleared by the sink

    always #4 aclk = ~aclk;

    rgb_led_effect_generator #(
        .DELAY_WIDTH  (DELAY_WIDTH),
        .HUE_INCREMENT(HUE_INCREMENT)
    ) dut (.*);

    led_frame_checker #(
        .DELAY_WIDTH  (DELAY_WIDTH),
        .HUE_INCREMENT(HUE_INCREMENT)
    ) frame_check (.*);

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap(bit calm);
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(99, 0);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Favor the channel extremes a little.
    function automatic logic [7:0] random_color();
        case ($urandom_range(7, 0))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one tick; hold valid and payload until the block takes it.
    // Called and returns at a falling edge.
    task automatic send_tick(input logic restart);
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
        @(negedge aclk);
    endtask

    // Drop valid for a random number of cycles; scramble the idle payload.
    task automatic sender_gap(input bit calm);
        int unsigned gap;
        gap = pick_gap(calm);
        if (gap != 0) begin
            s_valid   <= 1'b0;
            s_restart <= 1'($urandom);
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic run_ticks(input int unsigned count, input int unsigned restart_per_mille,
                             input bit calm);
        for (int unsigned n = 0; n < count; n++) begin
            send_tick($urandom_range(999, 0) < restart_per_mille);
            sender_gap(calm);
        end
    endtask

    // Pause the sender until every predicted frame has come back, then let the
    // block settle on any tick still in flight that makes no frame.
    task automatic drain_frames();
        s_valid <= 1'b0;
        do @(negedge aclk); while (frames_pending != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [rleg_pkg::CFG_INDEX_WIDTH-1:0] index,
                             input logic [rleg_pkg::FRAME_DELAY_WIDTH-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Drain, then write every register. Unused upper data bits carry noise.
    task automatic set_effect(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input rleg_pkg::mode_t mode,
                              input logic [rleg_pkg::FRAME_DELAY_WIDTH-1:0] delay);
        drain_frames();
        write_reg(rleg_pkg::REG_BASE_RED,    {16'($urandom), red});
        write_reg(rleg_pkg::REG_BASE_GREEN,  {16'($urandom), green});
        write_reg(rleg_pkg::REG_BASE_BLUE,   {16'($urandom), blue});
        write_reg(rleg_pkg::REG_EFFECT_MODE, {22'($urandom), mode});
        write_reg(rleg_pkg::REG_FRAME_DELAY, delay);
    endtask

    // Frame sink: random back-pressure, plus one long hold on request.
    initial begin : frame_sink
        int unsigned gap;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                // refuse frames long enough for the block to back up into s_ready
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
            end else begin
                gap = pick_gap(sink_calm);
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        rleg_pkg::mode_t                        mode;
        logic [rleg_pkg::FRAME_DELAY_WIDTH-1:0] delay;

        // hold reset once at the start, then release it
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Steady after reset: the first tick emits the base color, then nothing;
        // a restart lets it emit once more.
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // Blink with delay zero: a frame on every tick, restart back to the color.
        set_effect(8'hFF, 8'hFF, 8'hFF, rleg_pkg::MODE_BLINK, '0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);

        // Blink every second tick; the phase carries over the register change.
        set_effect(8'hFF, 8'h00, 8'h80, rleg_pkg::MODE_BLINK, 24'd2);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);

        // Largest delay: one frame after restart, then a long countdown.
        set_effect(8'hFF, 8'hFF, 8'hFF, rleg_pkg::MODE_FADE, '1);
        send_tick(1'b1);
        send_tick(1'b0);
        set_effect(8'h00, 8'h00, 8'h00, rleg_pkg::MODE_RAINBOW, '1);
        send_tick(1'b1);
        send_tick(1'b0);

        // Rainbow with delay zero: the countdown carries over the delay change, so no frame comes.
        set_effect(8'h00, 8'h00, 8'h00, rleg_pkg::MODE_RAINBOW, '0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);

        // Switch into steady, no restart: one frame, then silence; a restart brings one more.
        set_effect(8'd10, 8'd20, 8'd30, rleg_pkg::MODE_STEADY, '0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);

        // Fade with a delay below 256: period clamps to one tick.
        set_effect(8'h00, 8'h00, 8'h00, rleg_pkg::MODE_FADE, 24'd200);
        send_tick(1'b0);
        send_tick(1'b0);

        // Long fade run: crosses both turnarounds.
        sink_calm = ($urandom_range(1, 0) == 0);
        set_effect(random_color(), random_color(), random_color(), rleg_pkg::MODE_FADE,
                   rleg_pkg::FRAME_DELAY_WIDTH'($urandom_range(255, 0)));
        run_ticks(560, 0, $urandom_range(1, 0) == 0);

        // Long rainbow run: wraps the hue twice.
        sink_calm = ($urandom_range(1, 0) == 0);
        set_effect(random_color(), random_color(), random_color(), rleg_pkg::MODE_RAINBOW,
                   rleg_pkg::FRAME_DELAY_WIDTH'($urandom_range(1, 0)));
        run_ticks(400, 0, $urandom_range(1, 0) == 0);

        // Long output stall while ticks keep coming, so the block stalls its input.
        sink_calm = 1'b0;
        set_effect(random_color(), random_color(), random_color(), rleg_pkg::MODE_RAINBOW,
                   '0);
        long_hold_req = 1'b1;
        run_ticks(40, 0, 1'b1);
        while (long_hold_req)
            @(negedge aclk);

        // Mixed settings with short delays; the pattern state carries across phases.
        for (int unsigned phase = 0; phase < MIXED_PHASES; phase++) begin
            mode  = rleg_pkg::mode_t'($urandom_range(3, 0));
            delay = (mode == rleg_pkg::MODE_FADE)
                  ? rleg_pkg::FRAME_DELAY_WIDTH'($urandom_range(1535, 0))
                  : rleg_pkg::FRAME_DELAY_WIDTH'($urandom_range(6, 0));
            sink_calm = ($urandom_range(3, 0) == 0);
            set_effect(random_color(), random_color(), random_color(), mode, delay);
            run_ticks(60, 40, $urandom_range(3, 0) == 0);
        end

        // wait out every frame, then a short tail for anything extra
        drain_frames();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Sent %0d ticks and checked %0d frames: directed cases, full fade",
                 ticks_sent, frames_checked);
        $display("and rainbow cycles, one long output stall and %0d mixed settings.",
                 MIXED_PHASES);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rleg_pkg.sv
hw/rtl/rgb_led_effect_generator.sv
hw/rtl/rleg_port_check.sv
tb/led_frame_checker.sv
tb/tb_top.sv
